// ===== hw/rtl/psu_pkg.sv =====
package psu_pkg;

	localparam int MAX_ROW_LEN = 4096;
	localparam int MAX_BPP     = 4;

	localparam int POS_W     = 13;
	localparam int BPP_W     = 3;
	localparam int ADDR_W    = $clog2(MAX_ROW_LEN);
	localparam int BPP_IDX_W = $clog2(MAX_BPP);
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 13;

	localparam logic [CFG_IDX_W-1:0] REG_BPP     = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_ROW_LEN = CFG_IDX_W'(1);

	localparam logic [BPP_W-1:0] BPP_RESET     = BPP_W'(3);
	localparam logic [POS_W-1:0] ROW_LEN_RESET = POS_W'(3);

	typedef enum logic [2:0] {
		FILT_NONE  = 3'd0,
		FILT_SUB   = 3'd1,
		FILT_UP    = 3'd2,
		FILT_AVG   = 3'd3,
		FILT_PAETH = 3'd4
	} filt_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       start_of_image;
	} in_t;

	typedef struct packed {
		logic [7:0] pixel_byte;
		logic       status;
		logic       end_of_row;
	} out_t;

	// Paeth predictor: a = left, b = up, c = up-left; ties favor a, then b
	function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
	                                     input logic [7:0] c);
		logic signed [9:0] da;
		logic signed [9:0] db;
		logic signed [9:0] dc;
		logic [9:0] pa;
		logic [9:0] pb;
		logic [9:0] pc;
		da = $signed({2'b00, b}) - $signed({2'b00, c});
		db = $signed({2'b00, a}) - $signed({2'b00, c});
		dc = $signed({2'b00, a}) + $signed({2'b00, b}) - $signed({1'b0, c, 1'b0});
		pa = (da < 0) ? 10'(-da) : 10'(da);
		pb = (db < 0) ? 10'(-db) : 10'(db);
		pc = (dc < 0) ? 10'(-dc) : 10'(dc);
		if (pa <= pb && pa <= pc) begin
			return a;
		end else if (pb <= pc) begin
			return b;
		end
		return c;
	endfunction

endpackage

// ===== hw/rtl/png_scanline_unfilter.sv =====
// Channel  Dir  Handshake              Payload
// in       in   in_valid / in_ready    in_data   (psu_pkg::in_t: data_byte, start_of_image)
// out      out  out_valid / out_ready  out_data  (psu_pkg::out_t: pixel_byte, status, end_of_row)
// cfg      in   cfg_valid / cfg_ready  cfg_index, cfg_wdata (0 = bytes per pixel, 1 = row length)
//
// One request per clock sustained while the output is not stalled. A request is classified
// on acceptance (line store read issued the same edge), rebuilt in stage s1 and then
// registered into the output register. The single line store read port and the
// one-byte Sub/Paeth feedback through the left history set the one-byte-per-clock figure.
// Reset clears control and config; the line store holds garbage until rows are written.
// A stalled output holds s1; filter requests in s1 retire regardless of the output side.
module png_scanline_unfilter (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  psu_pkg::in_t                      in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output psu_pkg::out_t                     out_data,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [psu_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [psu_pkg::CFG_W-1:0]         cfg_wdata
);
	import psu_pkg::*;

	// what a request becomes inside s1
	typedef enum logic [1:0] {
		K_FILT,
		K_DATA,
		K_ERR
	} kind_t;

	// config registers
	logic [BPP_W-1:0] bpp_q;
	logic [POS_W-1:0] rb_q;

	// front-end row tracking, updated on acceptance
	logic [POS_W-1:0] pos_q;
	logic             first_q;
	logic             halted_q;
	filt_t            filt_q;

	// stage 1
	logic              vld_s1;
	kind_t             kind_s1;
	logic [7:0]        data_s1;
	filt_t             filt_s1;
	logic              first_s1;
	logic              eor_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [7:0]        up_rd_s1;

	// reconstructed-byte and up-byte histories of the current row
	logic [7:0] left_q [MAX_BPP];
	logic [7:0] ul_q   [MAX_BPP];

	// line store
	logic [7:0] line_mem [MAX_ROW_LEN];

	// output register
	logic out_vld_q;
	out_t out_q;

	// front-end decode
	logic              accept;
	logic              sos;
	logic              halt_eff;
	logic [POS_W-1:0]  pos_eff;
	logic              first_eff;
	logic              is_filt;
	logic              is_err;
	logic              is_data;
	logic [POS_W-1:0]  rb_eff;
	logic [POS_W-1:0]  idx;
	logic              eor;

	// stage 1 datapath
	logic                 s1_move;
	logic [BPP_W-1:0]     bpp_eff;
	logic [BPP_IDX_W-1:0] bsel;
	logic [7:0]           left;
	logic [7:0]           up;
	logic [7:0]           ul;
	logic [8:0]           avg_sum;
	logic [7:0]           recon;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpp_q <= BPP_RESET;
			rb_q  <= ROW_LEN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_BPP:     bpp_q <= cfg_wdata[BPP_W-1:0];
				REG_ROW_LEN: rb_q  <= cfg_wdata[POS_W-1:0];
				default:     ;
			endcase
		end
	end

	// out-of-range config clamps
	always_comb begin
		if (rb_q == '0) begin
			rb_eff = POS_W'(1);
		end else if (rb_q > POS_W'(MAX_ROW_LEN)) begin
			rb_eff = POS_W'(MAX_ROW_LEN);
		end else begin
			rb_eff = rb_q;
		end
		if (bpp_q == '0) begin
			bpp_eff = BPP_W'(1);
		end else if (bpp_q > BPP_W'(MAX_BPP)) begin
			bpp_eff = BPP_W'(MAX_BPP);
		end else begin
			bpp_eff = bpp_q;
		end
	end

	// s1 retires when its result can go to the output register, or it has none
	assign s1_move  = vld_s1 && (kind_s1 == K_FILT || !out_vld_q || out_ready);
	assign in_ready = !vld_s1 || s1_move;
	assign accept   = in_valid && in_ready;

	// start of image overrides the row state before anything else
	always_comb begin
		sos       = in_data.start_of_image;
		halt_eff  = halted_q && !sos;
		pos_eff   = sos ? '0 : pos_q;
		first_eff = sos ? 1'b1 : first_q;
		is_filt   = !halt_eff && pos_eff == '0 && in_data.data_byte <= 8'(FILT_PAETH);
		is_err    = !halt_eff && pos_eff == '0 && in_data.data_byte > 8'(FILT_PAETH);
		is_data   = !halt_eff && pos_eff != '0;
		idx       = pos_eff - POS_W'(1);
		// pos_eff equals idx + 1
		eor       = pos_eff >= rb_eff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			first_q  <= 1'b1;
			halted_q <= 1'b0;
			filt_q   <= FILT_NONE;
		end else if (accept) begin
			if (is_err) begin
				pos_q    <= pos_eff;
				first_q  <= first_eff;
				halted_q <= 1'b1;
			end else if (is_filt) begin
				filt_q   <= filt_t'(in_data.data_byte[2:0]);
				pos_q    <= POS_W'(1);
				first_q  <= first_eff;
				halted_q <= halt_eff;
			end else if (is_data) begin
				halted_q <= halt_eff;
				if (eor) begin
					pos_q   <= '0;
					first_q <= 1'b0;
				end else begin
					pos_q   <= pos_eff + POS_W'(1);
					first_q <= first_eff;
				end
			end else begin
				pos_q    <= pos_eff;
				first_q  <= first_eff;
				halted_q <= halt_eff;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= is_filt || is_err || is_data;
		end else if (s1_move) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1  <= is_err ? K_ERR : (is_data ? K_DATA : K_FILT);
			data_s1  <= in_data.data_byte;
			filt_s1  <= filt_q;
			first_s1 <= first_eff;
			eor_s1   <= eor;
			addr_s1  <= idx[ADDR_W-1:0];
		end
	end

	// line store: read on acceptance, write when the rebuilt byte retires;
	// a row entry is always written before the next row reads it
	always_ff @(posedge clk) begin
		if (accept && is_data) begin
			up_rd_s1 <= line_mem[idx[ADDR_W-1:0]];
		end
		if (s1_move && kind_s1 == K_DATA) begin
			line_mem[addr_s1] <= recon;
		end
	end

	// reconstruction
	always_comb begin
		bsel    = BPP_IDX_W'(bpp_eff - BPP_W'(1));
		left    = left_q[bsel];
		ul      = ul_q[bsel];
		up      = first_s1 ? 8'd0 : up_rd_s1;
		avg_sum = {1'b0, left} + {1'b0, up};
		case (filt_s1)
			FILT_SUB:   recon = data_s1 + left;
			FILT_UP:    recon = data_s1 + up;
			FILT_AVG:   recon = data_s1 + avg_sum[8:1];
			FILT_PAETH: recon = data_s1 + paeth(left, up, ul);
			default:    recon = data_s1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_BPP; k++) begin
				left_q[k] <= '0;
				ul_q[k]   <= '0;
			end
		end else if (s1_move) begin
			if (kind_s1 == K_FILT) begin
				for (int k = 0; k < MAX_BPP; k++) begin
					left_q[k] <= '0;
					ul_q[k]   <= '0;
				end
			end else if (kind_s1 == K_DATA) begin
				for (int k = MAX_BPP - 1; k > 0; k--) begin
					left_q[k] <= left_q[k-1];
					ul_q[k]   <= ul_q[k-1];
				end
				left_q[0] <= recon;
				ul_q[0]   <= up;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (s1_move && kind_s1 != K_FILT) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move && kind_s1 != K_FILT) begin
			if (kind_s1 == K_ERR) begin
				out_q.pixel_byte <= 8'd0;
				out_q.status     <= 1'b1;
				out_q.end_of_row <= 1'b0;
			end else begin
				out_q.pixel_byte <= recon;
				out_q.status     <= 1'b0;
				out_q.end_of_row <= eor_s1;
			end
		end
	end

	assign out_valid = out_vld_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	// an error result carries no pixel and never ends a row
	a_err_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status |-> out_data.pixel_byte == 8'd0 && !out_data.end_of_row)
		else $error("error result with nonzero payload");

	// while halted, requests without start of image are dropped
	a_halt_drop: assert property (@(posedge clk) disable iff (!arst_n)
		accept && halted_q && !in_data.start_of_image |=> !vld_s1)
		else $error("request entered s1 while halted");

	// row position never runs past the line store
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_W'(MAX_ROW_LEN))
		else $error("row position beyond line store");

	// an error request always halts the front end
	a_err_halts: assert property (@(posedge clk) disable iff (!arst_n)
		accept && is_err |=> halted_q)
		else $error("unknown filter did not halt");
`endif

endmodule

// ===== dv/tb.sv =====
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import psu_pkg::*;

	// ---------------------------------------------------------------------------------
	// Run plan: a short directed stream first, then phases of random image streams,
	// each under its own bytes-per-pixel / row-length setting. A local model of the
	// unfilter tracks every accepted request and queues the byte it should produce.
	// ---------------------------------------------------------------------------------
	localparam int HALF_PERIOD   = 10;
	localparam int RESET_CYCLES  = 10;
	localparam int SETTLE_CYCLES = 8;     // margin for results still in the pipeline
	localparam int DRAIN_LIMIT   = 20000;
	localparam int HOLD_CYCLES   = 400;   // receiver back-pressure stretch
	localparam int IDLE_PCT      = 34;
	localparam int PHASE_ITEMS   = 90;
	localparam int BIG_ITEMS     = 380;
	localparam int BIG_PHASE     = 6;
	localparam int CALM_PHASE    = 6;     // the long row: no idling on either side
	localparam int HOLD_PHASE    = 4;
	localparam int PAUSE_PHASE   = 2;
	localparam int RANDOM_PHASES = 4;

	// fixed settings, extremes and out-of-range values among them
	localparam int PH_BPP  [8] = '{1, 0, 4, 7, 2, 3, 5, 4};
	localparam int PH_ROWS [8] = '{1, 0, 7, 5, 16, 33, 8191, 4};

	localparam out_t NO_RES = '0;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       soi;
		logic       pinned;     // 1: expected byte typed in below, else from the model
		out_t       want;
	} dir_row_t;

	// Reset setting: 3 bytes per pixel, 3 data bytes per row.
	localparam dir_row_t DIR_ROWS [29] = '{
		// first row, None: bytes pass straight through
		'{{5'd0, FILT_NONE},  1'b1, 1'b0, NO_RES},
		'{8'h00,              1'b0, 1'b1, '{8'h00, 1'b0, 1'b0}},
		'{8'hFF,              1'b0, 1'b1, '{8'hFF, 1'b0, 1'b0}},
		'{8'h80,              1'b0, 1'b1, '{8'h80, 1'b0, 1'b1}},
		// Sub with three bytes per pixel: left is still outside the row
		'{{5'd0, FILT_SUB},   1'b0, 1'b0, NO_RES},
		'{8'h10,              1'b0, 1'b1, '{8'h10, 1'b0, 1'b0}},
		'{8'hFF,              1'b0, 1'b1, '{8'hFF, 1'b0, 1'b0}},
		'{8'h01,              1'b0, 1'b1, '{8'h01, 1'b0, 1'b1}},
		// Up, Average, Paeth against the rows above
		'{{5'd0, FILT_UP},    1'b0, 1'b0, NO_RES},
		'{8'hF0,              1'b0, 1'b0, NO_RES},
		'{8'h02,              1'b0, 1'b0, NO_RES},
		'{8'h7F,              1'b0, 1'b0, NO_RES},
		'{{5'd0, FILT_AVG},   1'b0, 1'b0, NO_RES},
		'{8'h11,              1'b0, 1'b0, NO_RES},
		'{8'h22,              1'b0, 1'b0, NO_RES},
		'{8'h33,              1'b0, 1'b0, NO_RES},
		'{{5'd0, FILT_PAETH}, 1'b0, 1'b0, NO_RES},
		'{8'hC8,              1'b0, 1'b0, NO_RES},
		'{8'h05,              1'b0, 1'b0, NO_RES},
		'{8'hFE,              1'b0, 1'b0, NO_RES},
		// unknown filter type: error, then the stream is dropped
		'{8'h05,              1'b0, 1'b1, '{8'h00, 1'b1, 1'b0}},
		'{8'h07,              1'b0, 1'b0, NO_RES},
		// new image whose first filter byte is bad too
		'{8'hFF,              1'b1, 1'b1, '{8'h00, 1'b1, 1'b0}},
		// Paeth in the first row sees zeros everywhere
		'{{5'd0, FILT_PAETH}, 1'b1, 1'b0, NO_RES},
		'{8'h12,              1'b0, 1'b1, '{8'h12, 1'b0, 1'b0}},
		// start of image in the middle of a row restarts at row zero
		'{{5'd0, FILT_SUB},   1'b1, 1'b0, NO_RES},
		'{8'h7F,              1'b0, 1'b1, '{8'h7F, 1'b0, 1'b0}},
		'{8'h81,              1'b0, 1'b1, '{8'h81, 1'b0, 1'b0}},
		'{8'h00,              1'b0, 1'b1, '{8'h00, 1'b0, 1'b1}}
	};

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	in_t                  in_data;
	logic                 out_valid;
	logic                 out_ready;
	out_t                 out_data;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;

	png_scanline_unfilter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// ---------------------------------------------------------------------------------
	// Local unfilter model state (reset values)
	// ---------------------------------------------------------------------------------
	logic [BPP_W-1:0] cfg_bpp  = BPP_RESET;
	logic [POS_W-1:0] cfg_rows = ROW_LEN_RESET;
	logic [7:0]       line_mem [MAX_ROW_LEN];     // row above
	logic [7:0]       left_hist [MAX_BPP];        // recent rebuilt bytes of this row
	logic [7:0]       corner_hist [MAX_BPP];      // recent "above" bytes of this row
	filt_t            cur_filt   = FILT_NONE;
	logic [POS_W-1:0] pos        = '0;            // 0: waiting for the filter byte
	bit               first_row  = 1'b1;
	bit               stopped    = 1'b0;          // after an unknown filter type

	out_t expected_pixels [$];
	out_t oldest;
	int   mismatches  = 0;
	bit   calm        = 1'b0;
	bit   hold_output = 1'b0;

	initial begin
		for (int i = 0; i < MAX_ROW_LEN; i++) begin
			line_mem[i] = '0;
		end
		for (int i = 0; i < MAX_BPP; i++) begin
			left_hist[i]   = '0;
			corner_hist[i] = '0;
		end
	end

	// ---------------------------------------------------------------------------------
	// Clock, reset, timeout
	// ---------------------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #HALF_PERIOD clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("png_scanline_unfilter: mismatch");
		$finish;
	end

	// ---------------------------------------------------------------------------------
	// Model
	// ---------------------------------------------------------------------------------
	function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
	                                          input logic [7:0] c);
		int est;
		int da;
		int db;
		int dc;
		est = int'(a) + int'(b) - int'(c);
		da  = est - int'(a);
		db  = est - int'(b);
		dc  = est - int'(c);
		if (da < 0) da = -da;
		if (db < 0) db = -db;
		if (dc < 0) dc = -dc;
		if (da <= db && da <= dc) begin
			return a;
		end else if (db <= dc) begin
			return b;
		end
		return c;
	endfunction

	// Advance the model by one accepted request; dropped = swallowed while stopped.
	task automatic unfilter_step(input in_t req, output bit has_res, output bit dropped,
	                             output out_t res);
		int unsigned col;
		int unsigned bpp;
		int unsigned rows;
		logic [7:0]  above;
		logic [7:0]  left_px;
		logic [7:0]  corner;
		logic [7:0]  pix;
		bit          eor;
		has_res = 1'b0;
		dropped = 1'b0;
		res     = NO_RES;
		if (req.start_of_image) begin
			stopped   = 1'b0;
			first_row = 1'b1;
			pos       = '0;
		end
		if (stopped) begin
			dropped = 1'b1;
		end else if (pos == 0) begin
			if (req.data_byte > 8'(FILT_PAETH)) begin
				stopped = 1'b1;
				has_res = 1'b1;
				res     = '{8'h00, 1'b1, 1'b0};
			end else begin
				cur_filt = filt_t'(req.data_byte[2:0]);
				for (int k = 0; k < MAX_BPP; k++) begin
					left_hist[k]   = '0;
					corner_hist[k] = '0;
				end
				pos = 1;
			end
		end else begin
			col  = pos - 1;
			bpp  = (cfg_bpp == 0) ? 1 : ((cfg_bpp > MAX_BPP) ? MAX_BPP : cfg_bpp);
			rows = (cfg_rows == 0) ? 1 :
			       ((cfg_rows > MAX_ROW_LEN) ? MAX_ROW_LEN : cfg_rows);
			above   = first_row ? 8'h00 : line_mem[col];
			left_px = left_hist[bpp-1];
			corner  = corner_hist[bpp-1];
			case (cur_filt)
				FILT_SUB:   pix = req.data_byte + left_px;
				FILT_UP:    pix = req.data_byte + above;
				FILT_AVG:   pix = req.data_byte + 8'((9'(left_px) + 9'(above)) >> 1);
				FILT_PAETH: pix = req.data_byte + paeth_pick(left_px, above, corner);
				default:    pix = req.data_byte;
			endcase
			for (int k = MAX_BPP - 1; k > 0; k--) begin
				left_hist[k]   = left_hist[k-1];
				corner_hist[k] = corner_hist[k-1];
			end
			left_hist[0]   = pix;
			corner_hist[0] = above;
			line_mem[col]  = pix;
			eor = (col + 1) >= rows;
			if (eor) begin
				pos       = '0;
				first_row = 1'b0;
			end else begin
				pos = pos + 1'b1;
			end
			has_res = 1'b1;
			res     = '{pix, 1'b0, eor};
		end
	endtask

	// ---------------------------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------------------------
	function automatic logic [7:0] pick_filter();
		return 8'($urandom_range(int'(FILT_PAETH), int'(FILT_NONE)));
	endfunction

	function automatic logic [7:0] pick_bad_filter();
		return 8'($urandom_range(255, int'(FILT_PAETH) + 1));
	endfunction

	// Mostly well-formed rows; soi_pm / bad_pm (per mille) inject restarts and bad filters.
	task automatic pick_request(input int soi_pm, input int bad_pm, output in_t req);
		int roll;
		int kind;
		roll = $urandom_range(999);
		kind = $urandom_range(9);
		req.start_of_image = 1'b0;
		if (stopped) begin
			// noise until a new image shows up
			if (roll < 300) begin
				req.start_of_image = 1'b1;
				req.data_byte      = (kind == 0) ? pick_bad_filter() : pick_filter();
			end else begin
				req.data_byte = 8'($urandom);
			end
		end else if (pos == 0) begin
			if (roll < bad_pm) begin
				req.data_byte      = pick_bad_filter();
				req.start_of_image = 1'($urandom_range(1));
			end else begin
				req.data_byte      = pick_filter();
				req.start_of_image = (roll < bad_pm + soi_pm);
			end
		end else if (roll < soi_pm) begin
			// restart in the middle of a row
			req.start_of_image = 1'b1;
			req.data_byte      = (kind == 0) ? pick_bad_filter() : pick_filter();
		end else begin
			case (kind)
				0:       req.data_byte = 8'h00;
				1:       req.data_byte = 8'hFF;
				default: req.data_byte = 8'($urandom);
			endcase
		end
	endtask

	// Drive one request, wait for it to be taken, then update the model.
	// Returns at the falling edge after acceptance with in_valid still high.
	task automatic offer(input in_t req, input bit pinned, input out_t pinned_res,
	                     output bit counted);
		bit   has_res;
		bit   dropped;
		out_t res;
		if (!calm) begin
			while ($urandom_range(99) < IDLE_PCT) begin
				in_valid <= 1'b0;
				@(negedge clk);
			end
		end
		in_valid <= 1'b1;
		in_data  <= req;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		unfilter_step(req, has_res, dropped, res);
		if (pinned) begin
			expected_pixels.push_back(pinned_res);
		end else if (has_res) begin
			expected_pixels.push_back(res);
		end
		counted = !dropped;
		@(negedge clk);
	endtask

	// Wait, from a falling edge, until every expected byte has come out.
	task automatic drain_wait();
		int waited;
		waited = 0;
		@(negedge clk);
		while (expected_pixels.size() != 0 && waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		if (expected_pixels.size() != 0) begin
			mismatches++;
			$display("%0t: %0d results never arrived", $realtime, expected_pixels.size());
		end
	endtask

	// Write both registers back to back; caller guarantees the block is idle.
	task automatic set_config(input int bpp_val, input int rows_val);
		cfg_valid <= 1'b1;
		cfg_index <= REG_BPP;
		cfg_wdata <= CFG_W'(bpp_val);
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_bpp = BPP_W'(bpp_val);
		@(negedge clk);
		cfg_index <= REG_ROW_LEN;
		cfg_wdata <= CFG_W'(rows_val);
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_rows = POS_W'(rows_val);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// One random phase: starts a fresh image so the line store is only read once written.
	task automatic feed_phase(input int budget, input int soi_pm, input int bad_pm,
	                          input bit mid_pause);
		in_t req;
		bit  counted;
		int  remaining;
		bit  fresh;
		remaining = budget;
		fresh     = 1'b1;
		while (remaining > 0) begin
			if (fresh) begin
				req.start_of_image = 1'b1;
				req.data_byte      = pick_filter();
				fresh              = 1'b0;
			end else begin
				pick_request(soi_pm, bad_pm, req);
			end
			offer(req, 1'b0, NO_RES, counted);
			if (counted) remaining--;
			// sender stops until the block has emptied out
			if (mid_pause && counted && remaining == budget / 2) begin
				in_valid <= 1'b0;
				drain_wait();
			end
		end
		in_valid <= 1'b0;
	endtask

	task automatic note_mismatch(input string what, input out_t want, input out_t got);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%0t: %s: want %02h/%0b/%0b, got %02h/%0b/%0b (pixel/status/eor)",
			         $realtime, what, want.pixel_byte, want.status, want.end_of_row,
			         got.pixel_byte, got.status, got.end_of_row);
		end
	endtask

	// ---------------------------------------------------------------------------------
	// Output side: random back-pressure, one long hold-off on request
	// ---------------------------------------------------------------------------------
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_output) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_output = 1'b0;
			end else if (calm) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// Compare every accepted result with the oldest expectation, field by field.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_pixels.size() == 0) begin
				note_mismatch("unexpected result", NO_RES, out_data);
			end else begin
				oldest = expected_pixels.pop_front();
				if (out_data.pixel_byte !== oldest.pixel_byte ||
				    out_data.status !== oldest.status ||
				    out_data.end_of_row !== oldest.end_of_row) begin
					note_mismatch("result differs", oldest, out_data);
				end
			end
		end
	end

	// ---------------------------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------------------------
	initial begin
		bit counted;
		in_t req;
		int bpp_val;
		int rows_val;
		int budget;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_BPP;
		cfg_wdata = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed stream under the reset setting
		foreach (DIR_ROWS[i]) begin
			req.data_byte      = DIR_ROWS[i].data_byte;
			req.start_of_image = DIR_ROWS[i].soi;
			offer(req, DIR_ROWS[i].pinned, DIR_ROWS[i].want, counted);
		end
		in_valid <= 1'b0;

		for (int p = 0; p < 8 + RANDOM_PHASES; p++) begin
			// registers change only with the block empty; filter bytes leave no
			// result behind, so give the pipeline its latency on top
			drain_wait();
			repeat (SETTLE_CYCLES) @(negedge clk);
			if (p < 8) begin
				bpp_val  = PH_BPP[p];
				rows_val = PH_ROWS[p];
			end else begin
				bpp_val  = $urandom_range(7);
				rows_val = $urandom_range(64, 1);
			end
			set_config(bpp_val, rows_val);
			calm = (p == CALM_PHASE);
			if (p == HOLD_PHASE) hold_output = 1'b1;
			if (p == BIG_PHASE) begin
				// a long stretch of one row at the clamped maximum length
				budget = BIG_ITEMS;
				feed_phase(budget, 0, 0, 1'b0);
			end else begin
				feed_phase(PHASE_ITEMS, 15, 30, p == PAUSE_PHASE);
			end
			calm = 1'b0;
		end

		drain_wait();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (mismatches == 0 && expected_pixels.size() == 0) begin
			$display("png_scanline_unfilter: match");
		end else begin
			$display("png_scanline_unfilter: mismatch");
		end
		$finish;
	end

endmodule
